FILE: design/mbrx_pkg.sv
// ---------------------------------------------------------------------------
// mbrx_pkg
// Types, codes and helpers shared by the Modbus RTU frame receiver.
// ---------------------------------------------------------------------------
package mbrx_pkg;

  // largest data area the receiver will ever take
  localparam logic [8:0] MAX_FRAME_BYTES = 9'd260;

  // fixed data lengths set by the function code
  localparam logic [8:0] SHORT_LEN      = 9'd4;
  localparam logic [8:0] MULTI_LEN      = 9'd7;
  // data byte that carries the byte count of a write-multiple frame
  localparam logic [8:0] BYTE_COUNT_IDX = 9'd4;
  // register address, quantity and byte count fields added to the byte count
  localparam logic [8:0] COUNT_EXTRA    = 9'd5;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // input commands
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // receive phase
  typedef enum logic [1:0] {
    PH_HUNT,
    PH_CODE,
    PH_DATA
  } phase_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_ACCEPT   = 3'd1,
    ST_FRAME_OK = 3'd2,
    ST_CRC_ERR  = 3'd3,
    ST_REJECT   = 3'd4,
    ST_TIMEOUT  = 3'd5
  } status_t;

  // configuration register indexes
  localparam logic [2:0] REG_STATION     = 3'd0;
  localparam logic [2:0] REG_READ_CODE   = 3'd1;
  localparam logic [2:0] REG_MULTI_CODE  = 3'd2;
  localparam logic [2:0] REG_SINGLE_CODE = 3'd3;
  localparam logic [2:0] REG_MAX_LEN     = 3'd4;
  localparam logic [2:0] REG_TIMEOUT     = 3'd5;

  typedef struct packed {
    logic [7:0]  station_address;
    logic [7:0]  read_code;
    logic [7:0]  write_multi_code;
    logic [7:0]  write_single_code;
    logic [8:0]  max_data_length;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] function_code;
    logic       data_valid;
    logic [8:0] data_index;
    logic [7:0] data_byte;
    logic [8:0] data_length;
  } result_t;

  // one byte into the reflected crc-16
  function automatic logic [15:0] crc_add(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: design/mbrx_if.sv
// ---------------------------------------------------------------------------
// mbrx_if
// Valid/ready channels of the receiver: input items and result items.
// ---------------------------------------------------------------------------
interface mbrx_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface mbrx_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] function_code;
  logic       data_valid;
  logic [8:0] data_index;
  logic [7:0] data_byte;
  logic [8:0] data_length;

  modport source (output valid, output status, output function_code, output data_valid,
                  output data_index, output data_byte, output data_length, input ready);
  modport sink   (input valid, input status, input function_code, input data_valid,
                  input data_index, input data_byte, input data_length, output ready);
endinterface

FILE: design/modbus_rtu_frame_receiver.sv
// ---------------------------------------------------------------------------
// modbus_rtu_frame_receiver
// Modbus RTU slave frame receiver: address hunt, length by function code,
// data streaming with index, crc-16 check and tick timeout.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    command, rx_byte
//   out_ch   out  valid/ready    status, function_code, data_valid,
//                                data_index, data_byte, data_length
//   cfg_*    in   write enable   cfg_index, cfg_wdata
//
// One item per cycle sustained while out_ch accepts every result. An item is
// held in the input register, then its result in the result register.
// The frame state and crc update as the result register loads.
// A stalled result holds the result register; the input register still takes
// one more item, then in_ch.ready drops until the result is taken.
// Synchronous active-low reset returns to address hunt with default registers.
// ---------------------------------------------------------------------------
module modbus_rtu_frame_receiver
  import mbrx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  mbrx_in_if.sink     in_ch,
  mbrx_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  cfg_t       cfg;
  result_t    result;

  logic       in_v_r, in_v_nxt;
  logic       in_cmd_r;
  logic [7:0] in_byte_r;
  logic       out_v_r, out_v_nxt;
  result_t    out_r;
  logic       advance;
  logic       in_take;

  mbrx_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mbrx_frame_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .step    (advance),
    .command (in_cmd_r),
    .rx_byte (in_byte_r),
    .result  (result)
  );

  // handshake control
  assign advance     = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign in_v_nxt    = in_take || (in_v_r && !advance);
  assign out_v_nxt   = advance || (out_v_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_cmd_r  <= in_ch.command;
      in_byte_r <= in_ch.rx_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.status        = out_r.status;
  assign out_ch.function_code = out_r.function_code;
  assign out_ch.data_valid    = out_r.data_valid;
  assign out_ch.data_index    = out_r.data_index;
  assign out_ch.data_byte     = out_r.data_byte;
  assign out_ch.data_length   = out_r.data_length;

endmodule

FILE: design/mbrx_cfg_regs.sv
// ---------------------------------------------------------------------------
// mbrx_cfg_regs
// Configuration register file, written through a plain write port.
// ---------------------------------------------------------------------------
module mbrx_cfg_regs
  import mbrx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_STATION:     cfg_nxt.station_address   = cfg_wdata[7:0];
        REG_READ_CODE:   cfg_nxt.read_code         = cfg_wdata[7:0];
        REG_MULTI_CODE:  cfg_nxt.write_multi_code  = cfg_wdata[7:0];
        REG_SINGLE_CODE: cfg_nxt.write_single_code = cfg_wdata[7:0];
        REG_MAX_LEN:     cfg_nxt.max_data_length   = cfg_wdata[8:0];
        REG_TIMEOUT:     cfg_nxt.timeout_ticks     = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.station_address   <= 8'd1;
      cfg_r.read_code         <= 8'd3;
      cfg_r.write_multi_code  <= 8'd16;
      cfg_r.write_single_code <= 8'd5;
      cfg_r.max_data_length   <= 9'd59;
      cfg_r.timeout_ticks     <= 16'd10;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: design/mbrx_frame_core.sv
// ---------------------------------------------------------------------------
// mbrx_frame_core
// Frame state machine, length tracking, crc-16 and timeout per item.
// ---------------------------------------------------------------------------
module mbrx_frame_core
  import mbrx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       step,
  input  logic       command,
  input  logic [7:0] rx_byte,
  output result_t    result
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [8:0]  len_r, len_nxt;
  logic [8:0]  cnt_r, cnt_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_low_r, crc_low_nxt;
  logic [16:0] tick_r, tick_nxt;

  logic        is_tick;
  logic [8:0]  limit;
  logic        code_short, code_multi, code_reject;
  logic [8:0]  code_len;
  logic        cur_short, data_take, crc_low_slot;
  logic        len_update, len_reject;
  logic [8:0]  new_len;
  logic [16:0] tick_inc;
  logic        timed_out;
  logic [15:0] crc_upd;
  logic        crc_ok;

  // shared decode
  assign is_tick      = (command == CMD_TICK);
  assign limit        = (cfg.max_data_length < MAX_FRAME_BYTES) ? cfg.max_data_length
                                                                 : MAX_FRAME_BYTES;
  assign code_short   = (rx_byte == cfg.read_code) || (rx_byte == cfg.write_single_code);
  assign code_multi   = (rx_byte == cfg.write_multi_code);
  assign code_len     = code_short ? SHORT_LEN : MULTI_LEN;
  assign code_reject  = !(code_short || code_multi) || (code_len > limit);
  assign cur_short    = (code_r == cfg.read_code) || (code_r == cfg.write_single_code);
  assign data_take    = (cnt_r < len_r);
  assign crc_low_slot = (cnt_r == len_r);
  assign len_update   = data_take && (cnt_r == BYTE_COUNT_IDX)
                        && (code_r == cfg.write_multi_code) && !cur_short;
  assign new_len      = {1'b0, rx_byte} + COUNT_EXTRA;
  assign len_reject   = len_update && (new_len > limit);
  assign tick_inc     = tick_r + 17'd1;
  assign timed_out    = (tick_inc >= {1'b0, cfg.timeout_ticks});
  assign crc_upd      = crc_add((phase_r == PH_HUNT) ? CRC_INIT : crc_r, rx_byte);
  assign crc_ok       = ({rx_byte, crc_low_r} == crc_r);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (is_tick) begin
      if (phase_r != PH_HUNT && timed_out) begin
        phase_nxt = PH_HUNT;
      end
    end else begin
      unique case (phase_r)
        PH_HUNT: if (rx_byte == cfg.station_address) phase_nxt = PH_CODE;
        PH_CODE: phase_nxt = code_reject ? PH_HUNT : PH_DATA;
        PH_DATA: begin
          if (data_take) begin
            if (len_reject) phase_nxt = PH_HUNT;
          end else if (!crc_low_slot) begin
            phase_nxt = PH_HUNT;
          end
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    code_nxt    = code_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    crc_nxt     = crc_r;
    crc_low_nxt = crc_low_r;
    tick_nxt    = tick_r;
    result      = '0;
    result.status = ST_IDLE;
    if (is_tick) begin
      if (phase_r != PH_HUNT) begin
        tick_nxt = tick_inc;
        if (timed_out) begin
          result.status = ST_TIMEOUT;
          len_nxt  = '0;
          cnt_nxt  = '0;
          tick_nxt = '0;
        end
      end
    end else begin
      unique case (phase_r)
        PH_HUNT: begin
          if (rx_byte == cfg.station_address) begin
            result.status = ST_ACCEPT;
            crc_nxt  = crc_upd;
            tick_nxt = '0;
            cnt_nxt  = '0;
          end
        end
        PH_CODE: begin
          code_nxt = rx_byte;
          if (code_reject) begin
            result.status = ST_REJECT;
            len_nxt  = '0;
            cnt_nxt  = '0;
            tick_nxt = '0;
          end else begin
            result.status = ST_ACCEPT;
            len_nxt = code_len;
            cnt_nxt = '0;
            crc_nxt = crc_upd;
          end
        end
        PH_DATA: begin
          if (data_take) begin
            result.status     = ST_ACCEPT;
            result.data_valid = 1'b1;
            result.data_index = cnt_r;
            result.data_byte  = rx_byte;
            crc_nxt = crc_upd;
            cnt_nxt = cnt_r + 9'd1;
            if (len_reject) begin
              result.status = ST_REJECT;
              len_nxt  = '0;
              cnt_nxt  = '0;
              tick_nxt = '0;
            end else if (len_update) begin
              len_nxt = new_len;
            end
          end else if (crc_low_slot) begin
            result.status = ST_ACCEPT;
            crc_low_nxt = rx_byte;
            cnt_nxt     = cnt_r + 9'd1;
          end else begin
            result.status = crc_ok ? ST_FRAME_OK : ST_CRC_ERR;
            cnt_nxt  = '0;
            tick_nxt = '0;
          end
        end
        default: result.status = ST_IDLE;
      endcase
    end
    result.function_code = code_nxt;
    result.data_length   = len_nxt;
  end

  // frame state registers, advanced once per processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      code_r    <= '0;
      len_r     <= '0;
      cnt_r     <= '0;
      crc_r     <= CRC_INIT;
      crc_low_r <= '0;
      tick_r    <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      code_r    <= code_nxt;
      len_r     <= len_nxt;
      cnt_r     <= cnt_nxt;
      crc_r     <= crc_nxt;
      crc_low_r <= crc_low_nxt;
      tick_r    <= tick_nxt;
    end
  end

endmodule

FILE: verif/modbus_rtu_frame_receiver_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// modbus_rtu_frame_receiver_tb
// Feeds received bytes and timer ticks into the frame receiver and checks
// every result against a behavioral model of the frame state machine and
// crc-16. Directed frames hit the corner cases first. Random frames then run
// under many register settings, with random gaps and stalls on both channels.
// ---------------------------------------------------------------------------
module modbus_rtu_frame_receiver_tb;
  import mbrx_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 1050;
  localparam int PHASE_ITEMS  = 150;
  localparam int DRAIN_CYCLES = 4;
  localparam int REPORT_LINES = 40;

  typedef logic [7:0] byte_list_t[$];

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  bit src_gaps_on    = 1'b1;
  bit sink_stalls_on = 1'b1;

  int mismatches;
  int items_sent;
  int results_seen;

  mbrx_in_if  rx_bus ();
  mbrx_out_if res_bus ();

  modbus_rtu_frame_receiver uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (rx_bus),
    .out_ch    (res_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // receiver model: registers and frame state
  cfg_t        regs_m;
  phase_t      phase_m;
  logic [7:0]  code_m;
  logic [8:0]  len_m;
  logic [8:0]  count_m;
  logic [15:0] crc_m;
  logic [7:0]  crc_low_m;
  logic [16:0] ticks_m;

  result_t responses_due[$];

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // gap length: mostly none, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // reflected crc-16, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic logic [8:0] len_cap();
    return (regs_m.max_data_length < MAX_FRAME_BYTES) ? regs_m.max_data_length
                                                      : MAX_FRAME_BYTES;
  endfunction

  function automatic bit fixed_len_code(input logic [7:0] c);
    return (c == regs_m.read_code) || (c == regs_m.write_single_code);
  endfunction

  function automatic void drop_frame();
    phase_m = PH_HUNT;
    len_m   = '0;
    count_m = '0;
    ticks_m = '0;
  endfunction

  function automatic void reset_model();
    regs_m.station_address   = 8'd1;
    regs_m.read_code         = 8'd3;
    regs_m.write_multi_code  = 8'd16;
    regs_m.write_single_code = 8'd5;
    regs_m.max_data_length   = 9'd59;
    regs_m.timeout_ticks     = 16'd10;
    phase_m   = PH_HUNT;
    code_m    = '0;
    len_m     = '0;
    count_m   = '0;
    crc_m     = CRC_INIT;
    crc_low_m = '0;
    ticks_m   = '0;
  endfunction

  // response of the receiver to one byte or tick, advancing the model
  function automatic result_t frame_response(input logic cmd, input logic [7:0] b);
    result_t    r;
    logic [8:0] idx;
    logic [9:0] new_len;
    bit         known;
    r = '0;
    r.status = ST_IDLE;
    if (cmd == CMD_TICK) begin
      if (phase_m != PH_HUNT) begin
        ticks_m = ticks_m + 17'd1;
        if (ticks_m >= {1'b0, regs_m.timeout_ticks}) begin
          r.status = ST_TIMEOUT;
          drop_frame();
        end
      end
    end else if (phase_m == PH_HUNT) begin
      if (b == regs_m.station_address) begin
        r.status = ST_ACCEPT;
        crc_m    = crc16_byte(CRC_INIT, b);
        ticks_m  = '0;
        count_m  = '0;
        phase_m  = PH_CODE;
      end
    end else if (phase_m == PH_CODE) begin
      code_m  = b;
      known   = 1'b1;
      new_len = '0;
      if (fixed_len_code(b)) begin
        new_len = {1'b0, SHORT_LEN};
      end else if (b == regs_m.write_multi_code) begin
        new_len = {1'b0, MULTI_LEN};
      end else begin
        known = 1'b0;
      end
      if (!known || new_len > {1'b0, len_cap()}) begin
        r.status = ST_REJECT;
        drop_frame();
      end else begin
        r.status = ST_ACCEPT;
        len_m    = new_len[8:0];
        count_m  = '0;
        crc_m    = crc16_byte(crc_m, b);
        phase_m  = PH_DATA;
      end
    end else begin
      idx = count_m;
      if (idx < len_m) begin
        r.status     = ST_ACCEPT;
        r.data_valid = 1'b1;
        r.data_index = idx;
        r.data_byte  = b;
        crc_m        = crc16_byte(crc_m, b);
        count_m      = idx + 9'd1;
        // byte count of a write-multiple frame sets the real length
        if (idx == BYTE_COUNT_IDX && code_m == regs_m.write_multi_code &&
            !fixed_len_code(code_m)) begin
          new_len = {2'b00, b} + {1'b0, COUNT_EXTRA};
          if (new_len > {1'b0, len_cap()}) begin
            r.status = ST_REJECT;
            drop_frame();
          end else begin
            len_m = new_len[8:0];
          end
        end
      end else if (idx == len_m) begin
        r.status  = ST_ACCEPT;
        crc_low_m = b;
        count_m   = idx + 9'd1;
      end else begin
        r.status = ({b, crc_low_m} == crc_m) ? ST_FRAME_OK : ST_CRC_ERR;
        phase_m  = PH_HUNT;
        count_m  = '0;
        ticks_m  = '0;
      end
    end
    r.function_code = code_m;
    r.data_length   = len_m;
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    if (mismatches < REPORT_LINES) $display("mismatch at result %0d: %s", results_seen, what);
    mismatches++;
  endtask

  // one input transfer, with an optional gap before it
  task automatic send_item(input logic cmd, input logic [7:0] b);
    int gap;
    gap = src_gaps_on ? idle_len() : 0;
    if (gap > 0) begin
      rx_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_bus.valid   <= 1'b1;
    rx_bus.command <= cmd;
    rx_bus.rx_byte <= b;
    do @(posedge clk); while (!rx_bus.ready);
    responses_due.push_back(frame_response(cmd, b));
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, 8'($urandom_range(0, 255)));
  endtask

  // hold off the sender until every response is back and the pipe is empty
  task automatic wait_idle();
    rx_bus.valid <= 1'b0;
    while (responses_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_STATION:     regs_m.station_address   = val[7:0];
      REG_READ_CODE:   regs_m.read_code         = val[7:0];
      REG_MULTI_CODE:  regs_m.write_multi_code  = val[7:0];
      REG_SINGLE_CODE: regs_m.write_single_code = val[7:0];
      REG_MAX_LEN:     regs_m.max_data_length   = val[8:0];
      REG_TIMEOUT:     regs_m.timeout_ticks     = val;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [7:0] st, input logic [7:0] rc,
                               input logic [7:0] mc, input logic [7:0] sc,
                               input logic [8:0] ml, input logic [15:0] to);
    wait_idle();
    write_reg(REG_STATION, {8'h00, st});
    write_reg(REG_READ_CODE, {8'h00, rc});
    write_reg(REG_MULTI_CODE, {8'h00, mc});
    write_reg(REG_SINGLE_CODE, {8'h00, sc});
    write_reg(REG_MAX_LEN, {7'h00, ml});
    write_reg(REG_TIMEOUT, to);
  endtask

  // address, code and random data bytes
  function automatic byte_list_t frame_body(input logic [7:0] addr, input logic [7:0] code,
                                            input int ndata);
    byte_list_t q;
    q.push_back(addr);
    q.push_back(code);
    repeat (ndata) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  function automatic byte_list_t multi_body(input logic [7:0] addr, input logic [7:0] cnt);
    byte_list_t q;
    q = frame_body(addr, regs_m.write_multi_code, int'(cnt) + 5);
    q[6] = cnt;
    return q;
  endfunction

  // frame bytes plus crc, ticks sprinkled in at the given percentage
  task automatic send_frame(input byte_list_t body, input bit crc_ok, input int tick_pct);
    logic [15:0] crc;
    crc = CRC_INIT;
    foreach (body[i]) begin
      if (tick_pct > 0 && $urandom_range(0, 99) < tick_pct) send_tick();
      send_item(CMD_BYTE, body[i]);
      crc = crc16_byte(crc, body[i]);
    end
    if (!crc_ok) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    send_item(CMD_BYTE, crc[7:0]);
    send_item(CMD_BYTE, crc[15:8]);
  endtask

  // corner cases under the reset settings
  task automatic test_directed();
    byte_list_t f;
    send_tick();
    send_item(CMD_BYTE, 8'hFF);
    f = '{regs_m.station_address, regs_m.read_code, 8'h00, 8'hFF, 8'h00, 8'hFF};
    send_frame(f, 1'b1, 0);
    // byte count of zero: crc follows right after it
    f = '{regs_m.station_address, regs_m.write_multi_code,
          8'hA5, 8'h5A, 8'hFF, 8'h00, 8'h00};
    send_frame(f, 1'b0, 0);
    send_item(CMD_BYTE, regs_m.station_address);
    send_item(CMD_BYTE, 8'h00);
    // byte count beyond the length limit
    f = '{regs_m.station_address, regs_m.write_multi_code,
          8'h01, 8'h02, 8'h03, 8'h04, 8'd60};
    foreach (f[i]) send_item(CMD_BYTE, f[i]);
  endtask

  // equal codes: the fixed-length codes win
  task automatic test_code_priority();
    apply_setting(8'd1, 8'd16, 8'd16, 8'd5, 9'd59, 16'd10);
    send_frame(frame_body(8'd1, 8'd16, 4), 1'b1, 0);
    apply_setting(8'd1, 8'd3, 8'd16, 8'd16, 9'd59, 16'd10);
    send_frame(frame_body(8'd1, 8'd16, 4), 1'b1, 0);
    send_frame(frame_body(8'd1, 8'd3, 4), 1'b1, 0);
  endtask

  task automatic test_length_limits();
    apply_setting(8'd0, 8'd3, 8'd16, 8'd5, 9'd1, 16'd10);
    send_frame(frame_body(8'd0, 8'd3, 4), 1'b1, 0);
    apply_setting(8'd0, 8'd3, 8'd16, 8'd5, 9'd4, 16'd10);
    send_frame(multi_body(8'd0, 8'd2), 1'b1, 0);
    send_frame(frame_body(8'd0, 8'd5, 4), 1'b1, 0);
    apply_setting(8'd0, 8'd3, 8'd16, 8'd5, 9'd7, 16'd10);
    send_frame(multi_body(8'd0, 8'd2), 1'b1, 0);
    send_frame(multi_body(8'd0, 8'd3), 1'b1, 0);
    apply_setting(8'd255, 8'd0, 8'd255, 8'd128, MAX_FRAME_BYTES, 16'd10);
    send_frame(multi_body(8'd255, 8'd255), 1'b1, 0);
    send_frame(frame_body(8'd255, 8'd0, 4), 1'b0, 0);
  endtask

  task automatic test_timeouts();
    apply_setting(8'd1, 8'd3, 8'd16, 8'd5, 9'd59, 16'd1);
    send_item(CMD_BYTE, 8'd1);
    send_tick();
    apply_setting(8'd1, 8'd3, 8'd16, 8'd5, 9'd59, 16'd3);
    send_item(CMD_BYTE, 8'd1);
    send_item(CMD_BYTE, 8'd3);
    send_tick();
    send_tick();
    send_item(CMD_BYTE, 8'h77);
    send_tick();
    apply_setting(8'd1, 8'd3, 8'd16, 8'd5, 9'd59, 16'd65535);
    send_frame(multi_body(8'd1, 8'd6), 1'b1, 30);
  endtask

  // random settings and traffic, mostly well-formed frames
  task automatic test_random_traffic();
    int         start_count;
    int         phase_start;
    int         k;
    int         cut;
    logic [7:0] st;
    logic [7:0] rc;
    logic [7:0] mc;
    logic [7:0] sc;
    logic [8:0] ml;
    logic [15:0] to;
    logic [7:0] cnt;
    byte_list_t f;
    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      st = 8'($urandom_range(0, 255));
      rc = 8'($urandom_range(0, 255));
      mc = ($urandom_range(0, 99) < 15) ? rc : 8'($urandom_range(0, 255));
      sc = ($urandom_range(0, 99) < 15) ? mc : 8'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
        0:       ml = 9'd1;
        1:       ml = 9'($urandom_range(4, 7));
        2:       ml = MAX_FRAME_BYTES;
        3:       ml = 9'($urandom_range(61, 259));
        default: ml = 9'($urandom_range(20, 60));
      endcase
      case ($urandom_range(0, 5))
        0:       to = 16'd1;
        1:       to = 16'd65535;
        default: to = 16'($urandom_range(4, 40));
      endcase
      apply_setting(st, rc, mc, sc, ml, to);
      src_gaps_on    = ($urandom_range(0, 3) != 0);
      sink_stalls_on = ($urandom_range(0, 3) != 0);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        k = $urandom_range(0, 99);
        if (k < 30) begin
          f = frame_body(st, $urandom_range(0, 1) ? regs_m.read_code : regs_m.write_single_code,
                         4);
          send_frame(f, $urandom_range(0, 9) != 0, $urandom_range(0, 1) ? 0 : 5);
        end else if (k < 60) begin
          cnt = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 12));
          send_frame(multi_body(st, cnt), $urandom_range(0, 9) != 0,
                     $urandom_range(0, 1) ? 0 : 5);
        end else if (k < 70) begin
          // unknown or random code
          send_item(CMD_BYTE, st);
          send_item(CMD_BYTE, 8'($urandom_range(0, 255)));
        end else if (k < 80) begin
          // frame cut short
          f = multi_body(st, 8'($urandom_range(0, 8)));
          cut = $urandom_range(1, f.size() - 1);
          for (int i = 0; i < cut; i++) send_item(CMD_BYTE, f[i]);
        end else if (k < 90) begin
          repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 3) == 0) send_tick();
            else send_item(CMD_BYTE, $urandom_range(0, 1) ? st : 8'($urandom_range(0, 255)));
          end
        end else begin
          // tick-heavy frame to reach the timeout
          send_frame(frame_body(st, regs_m.read_code, 4), 1'b1, 40);
        end
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (responses_due.size() == 0) begin
        flag_mismatch("result transfer with nothing expected");
      end else begin
        want = responses_due.pop_front();
        if (res_bus.status !== want.status)
          flag_mismatch($sformatf("status %0d, expected %0d", res_bus.status, want.status));
        if (res_bus.function_code !== want.function_code)
          flag_mismatch($sformatf("function_code %0h, expected %0h",
                                  res_bus.function_code, want.function_code));
        if (res_bus.data_valid !== want.data_valid)
          flag_mismatch($sformatf("data_valid %0b, expected %0b",
                                  res_bus.data_valid, want.data_valid));
        if (res_bus.data_index !== want.data_index)
          flag_mismatch($sformatf("data_index %0d, expected %0d",
                                  res_bus.data_index, want.data_index));
        if (res_bus.data_byte !== want.data_byte)
          flag_mismatch($sformatf("data_byte %0h, expected %0h",
                                  res_bus.data_byte, want.data_byte));
        if (res_bus.data_length !== want.data_length)
          flag_mismatch($sformatf("data_length %0d, expected %0d",
                                  res_bus.data_length, want.data_length));
      end
      results_seen++;
    end
  end

  // result side pacing
  initial begin : sink_pacing
    int hold;
    hold = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        res_bus.ready <= 1'b0;
        hold--;
      end else if (sink_stalls_on && $urandom_range(0, 7) == 0) begin
        res_bus.ready <= 1'b0;
        hold = idle_len();
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // watchdog: too long without any transfer
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((rx_bus.valid && rx_bus.ready) || (res_bus.valid && res_bus.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL modbus_rtu_frame_receiver");
    $finish;
  end

  // test sequence
  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_STATION;
    cfg_wdata      <= '0;
    rx_bus.valid   <= 1'b0;
    rx_bus.command <= CMD_BYTE;
    rx_bus.rx_byte <= '0;
    mismatches   = 0;
    items_sent   = 0;
    results_seen = 0;
    reset_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_code_priority();
    test_length_limits();
    test_timeouts();
    test_random_traffic();
    wait_idle();

    if (mismatches == 0) begin
      $display("PASS modbus_rtu_frame_receiver");
    end else begin
      $display("FAIL modbus_rtu_frame_receiver");
    end
    $finish;
  end

endmodule
